FILE: design/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg
// Shared widths and verdict codes for the release/deadline schedule check.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int JOB_IDX_W = 4;
  localparam int CNT_W     = 5;
  localparam int MASK_W    = 16;
  localparam int TIME_W    = 16;
  localparam int LATEST_W  = 17;
  localparam int FIN_W     = 20;
  localparam int VERDICT_W = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_INFEASIBLE = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FEASIBLE   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OVERFLOW   = 2'd2;

endpackage

FILE: design/release_deadline_schedule_check_core.sv
// ----------------------------------------------------------------------------
// release_deadline_schedule_check_core
// Load a set of jobs, then decide whether one machine can run them all
// inside their start windows, using a subset table swept by one shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   A job word is taken at a rising edge with start high and busy low. Each
//   non-final word gives no result and leaves busy low. The word with
//   last_job set launches the check; done then pulses for one cycle with
//   verdict (0 infeasible, 1 feasible, 2 more than 16 jobs in the set).
//   An overflowing set answers in the cycle after its last word and leaves busy
//   low. Otherwise busy stays high through the search:
//     clearing pass over all 2^n subset table entries (n jobs in the set),
//     then a read of each subset's entry; a reachable subset other than the
//     full one tests each job of the set in turn, and each job that fits
//     proposes a finish time to its successor subset, kept if earlier.
//   done rises in the cycle busy falls.
//   The receiver cannot stall: done lasts exactly one cycle.
//   Reset (rst, synchronous) empties the job set and returns to idle.
// ----------------------------------------------------------------------------
module release_deadline_schedule_check_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rdsc_pkg::TIME_W-1:0]       release_time,
  input  logic [rdsc_pkg::TIME_W-1:0]       slack_window,
  input  logic [rdsc_pkg::TIME_W-1:0]       job_duration,
  input  logic                              last_job,
  output logic                              done,
  output logic [rdsc_pkg::VERDICT_W-1:0]    verdict
);
  import rdsc_pkg::*;

  localparam int TBL_DEPTH = 1 << MASK_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_MREAD = 6'b000100,
    S_MWAIT = 6'b001000,
    S_JTEST = 6'b010000,
    S_JWAIT = 6'b100000
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       job_count;
  logic [CNT_W-1:0]       count_next;
  logic [TIME_W-1:0]      release_store      [MAX_JOBS];
  logic [LATEST_W-1:0]    latest_start_store [MAX_JOBS];
  logic [TIME_W-1:0]      duration_store     [MAX_JOBS];
  logic [JOB_IDX_W-1:0]   last_idx;
  logic [MASK_W-1:0]      full_mask;
  logic [MASK_W-1:0]      used_mask;
  logic [MASK_W-1:0]      clr_addr;
  logic [JOB_IDX_W-1:0]   job_idx;
  logic [FIN_W-1:0]       cur_fin;
  logic [FIN_W-1:0]       new_fin;

  logic [FIN_W:0]         fin_mem [TBL_DEPTH];
  logic [FIN_W:0]         rd_q;
  logic                   mem_we;
  logic [MASK_W-1:0]      mem_waddr;
  logic [FIN_W:0]         mem_wdata;
  logic [MASK_W-1:0]      mem_raddr;

  logic [MASK_W-1:0]      job_bit;
  logic [MASK_W-1:0]      target;
  logic                   skip;
  logic [FIN_W-1:0]       start_t;
  logic [FIN_W:0]         sum;
  logic [FIN_W-1:0]       nf;

  assign busy = (state != S_IDLE);

  always_comb begin
    if (job_count < CNT_W'(MAX_JOBS)) begin
      count_next = job_count + CNT_W'(1);
    end else begin
      count_next = CNT_W'(MAX_JOBS + 1);
    end
  end

  always_comb begin
    job_bit = MASK_W'(1) << job_idx;
    target  = used_mask | job_bit;
    skip    = used_mask[job_idx] ||
              (FIN_W'(latest_start_store[job_idx]) < cur_fin);
    start_t = (FIN_W'(release_store[job_idx]) > cur_fin) ?
              FIN_W'(release_store[job_idx]) : cur_fin;
    sum     = (FIN_W+1)'(start_t) + (FIN_W+1)'(duration_store[job_idx]);
    nf      = sum[FIN_W] ? {FIN_W{1'b1}} : sum[FIN_W-1:0];
  end

  always_comb begin
    mem_raddr = (state == S_JTEST) ? target : used_mask;
    mem_we    = 1'b0;
    mem_waddr = target;
    mem_wdata = {1'b1, new_fin};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = {(clr_addr == '0), {FIN_W{1'b0}}};
      end
      S_JWAIT: begin
        mem_we = !rd_q[FIN_W] || (new_fin < rd_q[FIN_W-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fin_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= fin_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && job_count < CNT_W'(MAX_JOBS)) begin
      release_store[job_count[JOB_IDX_W-1:0]]      <= release_time;
      latest_start_store[job_count[JOB_IDX_W-1:0]] <=
        LATEST_W'(release_time) + LATEST_W'(slack_window);
      duration_store[job_count[JOB_IDX_W-1:0]]     <= job_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_count <= '0;
      used_mask <= '0;
      done      <= 1'b0;
      verdict   <= VERDICT_INFEASIBLE;
      last_idx  <= '0;
      full_mask <= '0;
      clr_addr  <= '0;
      job_idx   <= '0;
      cur_fin   <= '0;
      new_fin   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (last_job) begin
              job_count <= '0;
              if (count_next > CNT_W'(MAX_JOBS)) begin
                done    <= 1'b1;
                verdict <= VERDICT_OVERFLOW;
              end else begin
                last_idx  <= JOB_IDX_W'(count_next - CNT_W'(1));
                full_mask <= MASK_W'(((MASK_W+1)'(1) << count_next) - (MASK_W+1)'(1));
                clr_addr  <= '0;
                state     <= S_CLEAR;
              end
            end else begin
              job_count <= count_next;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + MASK_W'(1);
          if (clr_addr == full_mask) begin
            used_mask <= '0;
            state     <= S_MREAD;
          end
        end
        S_MREAD: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (used_mask == full_mask) begin
            done      <= 1'b1;
            verdict   <= rd_q[FIN_W] ? VERDICT_FEASIBLE : VERDICT_INFEASIBLE;
            used_mask <= '0;
            state     <= S_IDLE;
          end else if (!rd_q[FIN_W]) begin
            used_mask <= used_mask + MASK_W'(1);
            state     <= S_MREAD;
          end else begin
            cur_fin <= rd_q[FIN_W-1:0];
            job_idx <= '0;
            state   <= S_JTEST;
          end
        end
        S_JTEST: begin
          if (skip) begin
            if (job_idx == last_idx) begin
              used_mask <= used_mask + MASK_W'(1);
              state     <= S_MREAD;
            end else begin
              job_idx <= job_idx + JOB_IDX_W'(1);
            end
          end else begin
            new_fin <= nf;
            state   <= S_JWAIT;
          end
        end
        S_JWAIT: begin
          if (job_idx == last_idx) begin
            used_mask <= used_mask + MASK_W'(1);
            state     <= S_MREAD;
          end else begin
            job_idx <= job_idx + JOB_IDX_W'(1);
            state   <= S_JTEST;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/rdsc_checker.sv
// ----------------------------------------------------------------------------
// rdsc_checker
// Port-level checks for the release/deadline schedule check core.
// ----------------------------------------------------------------------------
module rdsc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           last_job,
  input logic                           done,
  input logic [rdsc_pkg::VERDICT_W-1:0] verdict
);
  import rdsc_pkg::*;

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (verdict == VERDICT_INFEASIBLE || verdict == VERDICT_FEASIBLE ||
              verdict == VERDICT_OVERFLOW))
    else $error("verdict holds an undefined code");

  a_busy_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && last_job))
    else $error("search began without a final job word");

  a_end_gives_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("search ended without a verdict");

  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("verdict shown while searching");

  a_quiet_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_job) |=> !done)
    else $error("verdict after a non-final job word");

endmodule

bind release_deadline_schedule_check_core rdsc_checker u_rdsc_checker (.*);
